FILE: hdl/dlst_pkg.sv
// ---------------------------------------------------------------------------
// dlst_pkg
// shared constants for the datagram loss and span tracker
// ---------------------------------------------------------------------------
`default_nettype none

package dlst_pkg;

   localparam int DEF_FRAMES    = 256;
   localparam int DEF_MAX_COUNT = 1024;

   localparam logic [31:0] MAGIC_RESET   = 32'h4252_5553;
   localparam logic [10:0] MAX_LEN_RESET = 11'd1200;
   localparam logic [10:0] MIN_LEN       = 11'd16;

   // csr indexes
   localparam logic CSR_MAGIC   = 1'b0;
   localparam logic CSR_MAX_LEN = 1'b1;

   // reject codes
   localparam logic [2:0] RC_OK        = 3'd0;
   localparam logic [2:0] RC_BAD_LEN   = 3'd1;
   localparam logic [2:0] RC_BAD_MAGIC = 3'd2;
   localparam logic [2:0] RC_BAD_COUNT = 3'd3;
   localparam logic [2:0] RC_BAD_SEQ   = 3'd4;
   localparam logic [2:0] RC_BAD_FRAME = 3'd5;

   localparam int REQ_W = 272;
   localparam int RSP_W = 176;

endpackage

`default_nettype wire

FILE: hdl/datagram_loss_span_tracker_top.sv
// ---------------------------------------------------------------------------
// datagram_loss_span_tracker_top
// checks datagram headers and keeps a per-frame loss and time-span record
// ---------------------------------------------------------------------------
// one header enters on req_* and exactly one verdict leaves on rsp_*, carrying
// the reject code and the frame record after the update. the csr port sets the
// expected magic word and the largest accepted length; write it while idle.
// items are handled one at a time: a transfer is taken only when the sequencer
// is idle, then the read state takes the frame record and seen bit from the
// memories, the calc state computes the update and the write state writes it
// back and loads the output register; a rejected header skips the calc state
// and writes nothing back. when the frame's packet count changes the record
// restarts and its seen bits are swept, one per cycle, in the clear state. the
// record memory reads as cleared after reset through per-frame valid flops, so
// the first header to each frame after reset restarts it and sweeps its seen bits.
// the output register holds a result until rsp_tready; the next item may already
// be taken and waits at write-back while the result is stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module datagram_loss_span_tracker_top #(
   parameter int FRAMES    = dlst_pkg::DEF_FRAMES,
   parameter int MAX_COUNT = dlst_pkg::DEF_MAX_COUNT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // length_bytes, header_magic, frame_number, sequence_number, packet_count,
   // user_time_ns, kernel_time_ns, zero pad
   input  wire [dlst_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // reject_code, was_duplicate, frame_slot, received_count, expected_count,
   // lost_count, user_time_span, kernel_time_span, zero pad
   output logic [dlst_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire                          csr_we,
   input  wire                          csr_index,
   input  wire [31:0]                   csr_wdata
);
   import dlst_pkg::*;

   localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int SW    = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
   localparam int CW    = $clog2(MAX_COUNT + 1);
   localparam int REC_W = 2 * CW + 256;
   localparam int SEEN_DEPTH = FRAMES * (2 ** SW);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_CLEAR = 3'd2;
   localparam logic [2:0] S_CALC  = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;

   // input fields
   logic [10:0] in_len;
   logic [31:0] in_magic, in_frame, in_seq, in_count;
   logic [63:0] in_ut, in_kt;

   assign in_len   = req_tdata[10:0];
   assign in_magic = req_tdata[42:11];
   assign in_frame = req_tdata[74:43];
   assign in_seq   = req_tdata[106:75];
   assign in_count = req_tdata[138:107];
   assign in_ut    = req_tdata[202:139];
   assign in_kt    = req_tdata[266:203];

   logic [31:0] magic_ff;
   logic [10:0] max_len_ff;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  code_ff, code_in;
   logic [FW-1:0] frame_ff;
   logic [SW-1:0] seq_ff;
   logic [CW-1:0] count_ff;
   logic [63:0] ut_ff, kt_ff;
   logic        dup_ff, dup_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic [FRAMES-1:0] vld_ff;

   // record fields
   logic [CW-1:0] exp_ff, exp_in, recv_ff, recv_in;
   logic [63:0]   uf_ff, uf_in, ul_ff, ul_in, kf_ff, kf_in, kl_ff, kl_in;

   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              accept, adv, rec_we, seen_we, seen_wdata;
   logic [REC_W-1:0]  rec_rdata, rec_rd;
   logic [FW+SW-1:0]  seen_waddr;
   logic              seen_rdata;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // header checks
   always_comb begin
      if (in_len < MIN_LEN || in_len > max_len_ff) begin
         code_in = RC_BAD_LEN;
      end else if (in_magic != magic_ff) begin
         code_in = RC_BAD_MAGIC;
      end else if (in_count == 32'd0 || in_count > 32'(MAX_COUNT)) begin
         code_in = RC_BAD_COUNT;
      end else if (in_seq >= in_count) begin
         code_in = RC_BAD_SEQ;
      end else if (in_frame >= 32'(FRAMES)) begin
         code_in = RC_BAD_FRAME;
      end else begin
         code_in = RC_OK;
      end
   end

   assign rec_rd = vld_ff[frame_ff] ? rec_rdata : '0;

   always_comb begin
      state_in    = state_ff;
      dup_in      = dup_ff;
      clr_in      = clr_ff;
      exp_in      = exp_ff;
      recv_in     = recv_ff;
      uf_in       = uf_ff;
      ul_in       = ul_ff;
      kf_in       = kf_ff;
      kl_in       = kl_ff;
      rsp_data_in = rsp_data_ff;
      rec_we      = 1'b0;
      seen_we     = 1'b0;
      seen_wdata  = 1'b0;
      seen_waddr  = {frame_ff, clr_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            {exp_in, recv_in, uf_in, ul_in, kf_in, kl_in} = rec_rd;
            dup_in = seen_rdata;
            clr_in = '0;
            if (code_ff != RC_OK) begin
               state_in = S_WRITE;
            end else if (rec_rd[REC_W-1 -: CW] != count_ff) begin
               exp_in   = count_ff;
               recv_in  = '0;
               uf_in    = '0;
               ul_in    = '0;
               kf_in    = '0;
               kl_in    = '0;
               dup_in   = 1'b0;
               state_in = S_CLEAR;
            end else begin
               state_in = S_CALC;
            end
         end
         S_CLEAR: begin
            seen_we = 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == SW'(count_ff - 1'b1)) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (!dup_ff) begin
               recv_in = recv_ff + 1'b1;
            end
            if (uf_ff == 64'd0) begin
               uf_in = ut_ff;
            end
            ul_in = ut_ff;
            if (kt_ff != 64'd0) begin
               if (kf_ff == 64'd0 || kt_ff < kf_ff) begin
                  kf_in = kt_ff;
               end
               if (kt_ff > kl_ff) begin
                  kl_in = kt_ff;
               end
            end
            state_in = S_WRITE;
         end
         S_WRITE: begin
            seen_waddr = {frame_ff, seq_ff};
            seen_wdata = 1'b1;
            if (adv) begin
               state_in = S_IDLE;
               if (code_ff == RC_OK) begin
                  rec_we      = 1'b1;
                  seen_we     = 1'b1;
                  rsp_data_in = {3'd0, kl_ff - kf_ff, ul_ff - uf_ff,
                                 11'(exp_ff - recv_ff), 11'(exp_ff), 11'(recv_ff),
                                 8'(frame_ff), dup_ff, code_ff};
               end else begin
                  rsp_data_in = {173'd0, code_ff};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         magic_ff     <= MAGIC_RESET;
         max_len_ff   <= MAX_LEN_RESET;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_WRITE && adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rec_we) begin
            vld_ff[frame_ff] <= 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MAGIC:   magic_ff   <= csr_wdata;
               CSR_MAX_LEN: max_len_ff <= csr_wdata[10:0];
               default:     magic_ff   <= magic_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff  <= code_in;
         frame_ff <= in_frame[FW-1:0];
         seq_ff   <= in_seq[SW-1:0];
         count_ff <= in_count[CW-1:0];
         ut_ff    <= in_ut;
         kt_ff    <= in_kt;
      end
      dup_ff      <= dup_in;
      clr_ff      <= clr_in;
      exp_ff      <= exp_in;
      recv_ff     <= recv_in;
      uf_ff       <= uf_in;
      ul_ff       <= ul_in;
      kf_ff       <= kf_in;
      kl_ff       <= kl_in;
      rsp_data_ff <= rsp_data_in;
   end

   dlst_ram #(
      .WIDTH (REC_W),
      .DEPTH (FRAMES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr ($clog2(FRAMES)'(frame_ff)),
      .wr_data ({exp_ff, recv_ff, uf_ff, ul_ff, kf_ff, kl_ff}),
      .rd_en   (accept),
      .rd_addr ($clog2(FRAMES)'(in_frame[FW-1:0])),
      .rd_data (rec_rdata)
   );

   dlst_ram #(
      .WIDTH (1),
      .DEPTH (SEEN_DEPTH)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (seen_we),
      .wr_addr ($clog2(SEEN_DEPTH)'(seen_waddr)),
      .wr_data (seen_wdata),
      .rd_en   (accept),
      .rd_addr ($clog2(SEEN_DEPTH)'({in_frame[FW-1:0], in_seq[SW-1:0]})),
      .rd_data (seen_rdata)
   );

endmodule

`default_nettype wire

FILE: hdl/dlst_ram.sv
// ---------------------------------------------------------------------------
// dlst_ram
// simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module dlst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                         clock,
   input  wire                         wr_en,
   input  wire [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire [WIDTH-1:0]             wr_data,
   input  wire                         rd_en,
   input  wire [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [WIDTH-1:0]            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: test/datagram_loss_span_tracker_top_test.sv
// ---------------------------------------------------------------------------
// datagram_loss_span_tracker_top_test
// drives datagram headers through the loss and span tracker and compares
// every verdict and frame record against an internal frame-record predictor,
// with random idling on both sides, csr changes between phases and a long
// receiver hold-off
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module datagram_loss_span_tracker_top_test;
   import dlst_pkg::*;

   localparam int NFRAMES = DEF_FRAMES;
   localparam int NCOUNT  = DEF_MAX_COUNT;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [63:0] kernel_time;
      logic [63:0] user_time;
      logic [31:0] count;
      logic [31:0] seq;
      logic [31:0] frame;
      logic [31:0] magic;
      logic [10:0] len;
   } header_type;

   typedef struct packed {
      logic [63:0] kernel_span;
      logic [63:0] user_span;
      logic [10:0] lost;
      logic [10:0] expected;
      logic [10:0] received;
      logic [7:0]  slot;
      logic        dup;
      logic [2:0]  code;
   } verdict_type;

   localparam int HDR_W = $bits(header_type);

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_we = 0;
   logic csr_index = 0;
   logic [31:0] csr_wdata = '0;

   always #2 clock = ~clock;

   datagram_loss_span_tracker_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [31:0] magic_reg;
   logic [10:0] max_len_reg;
   logic [10:0] rec_expected [NFRAMES];
   logic [10:0] rec_received [NFRAMES];
   logic [63:0] rec_user_first [NFRAMES];
   logic [63:0] rec_user_last [NFRAMES];
   logic [63:0] rec_kern_first [NFRAMES];
   logic [63:0] rec_kern_last [NFRAMES];
   bit seen [NFRAMES][NCOUNT];

   verdict_type pending_verdicts[$];
   int errors = 0;
   bit quiet_tail = 0;
   bit rx_hold = 0;
   int idle_cycles = 0;
   int rx_gap = 0;

   function automatic verdict_type predict_verdict(header_type h);
      verdict_type v;
      int f;
      v = '0;
      if (h.len < MIN_LEN || h.len > max_len_reg) v.code = RC_BAD_LEN;
      else if (h.magic != magic_reg) v.code = RC_BAD_MAGIC;
      else if (h.count == 0 || h.count > NCOUNT) v.code = RC_BAD_COUNT;
      else if (h.seq >= h.count) v.code = RC_BAD_SEQ;
      else if (h.frame >= NFRAMES) v.code = RC_BAD_FRAME;
      else v.code = RC_OK;
      if (v.code != RC_OK) return v;
      f = h.frame;
      if ({21'd0, rec_expected[f]} != h.count) begin
         rec_expected[f] = h.count[10:0];
         rec_received[f] = 0;
         for (int i = 0; i < NCOUNT; i++) seen[f][i] = 0;
         rec_user_first[f] = 0;
         rec_user_last[f] = 0;
         rec_kern_first[f] = 0;
         rec_kern_last[f] = 0;
      end
      v.dup = seen[f][h.seq];
      if (!v.dup) begin
         seen[f][h.seq] = 1;
         rec_received[f]++;
      end
      if (rec_user_first[f] == 0) rec_user_first[f] = h.user_time;
      rec_user_last[f] = h.user_time;
      if (h.kernel_time != 0) begin
         if (rec_kern_first[f] == 0 || h.kernel_time < rec_kern_first[f])
            rec_kern_first[f] = h.kernel_time;
         if (h.kernel_time > rec_kern_last[f]) rec_kern_last[f] = h.kernel_time;
      end
      v.slot = f[7:0];
      v.received = rec_received[f];
      v.expected = rec_expected[f];
      v.lost = rec_expected[f] - rec_received[f];
      v.user_span = rec_user_last[f] - rec_user_first[f];
      v.kernel_span = rec_kern_last[f] - rec_kern_first[f];
      return v;
   endfunction

   task automatic send_header(header_type h);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= REQ_W'(h);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_verdicts.push_back(predict_verdict(h));
   endtask

   task automatic drain;
      req_tvalid <= 0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (NCOUNT + 20) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == CSR_MAGIC) magic_reg = val;
      else max_len_reg = val[10:0];
      @(posedge clock);
   endtask

   function automatic header_type good_header(int frame, int count, int seq);
      header_type h;
      h.len = $urandom_range(MIN_LEN, max_len_reg);
      h.magic = magic_reg;
      h.frame = frame;
      h.count = count;
      h.seq = seq;
      h.user_time = {$urandom, $urandom};
      h.kernel_time = ($urandom_range(0, 4) == 0) ? 64'd0 : {$urandom, $urandom};
      return h;
   endfunction

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            verdict_type got;
            verdict_type exp_v;
            got = verdict_type'(rsp_tdata[$bits(verdict_type)-1:0]);
            if (pending_verdicts.size() == 0) begin
               $display("%0t: unexpected verdict %h", $time, got);
               errors++;
            end else begin
               exp_v = pending_verdicts.pop_front();
               if (got.code != exp_v.code)
                  $display("%0t: reject_code exp %0d got %0d", $time, exp_v.code, got.code);
               if (got.dup != exp_v.dup)
                  $display("%0t: was_duplicate exp %0d got %0d", $time, exp_v.dup, got.dup);
               if (got.slot != exp_v.slot)
                  $display("%0t: frame_slot exp %0d got %0d", $time, exp_v.slot, got.slot);
               if (got.received != exp_v.received)
                  $display("%0t: received_count exp %0d got %0d", $time,
                           exp_v.received, got.received);
               if (got.expected != exp_v.expected)
                  $display("%0t: expected_count exp %0d got %0d", $time,
                           exp_v.expected, got.expected);
               if (got.lost != exp_v.lost)
                  $display("%0t: lost_count exp %0d got %0d", $time, exp_v.lost, got.lost);
               if (got.user_span != exp_v.user_span)
                  $display("%0t: user time span exp %h got %h", $time,
                           exp_v.user_span, got.user_span);
               if (got.kernel_span != exp_v.kernel_span)
                  $display("%0t: kernel time span exp %h got %h", $time,
                           exp_v.kernel_span, got.kernel_span);
               if (got != exp_v) errors++;
            end
         end
         if (rx_hold) begin
            rsp_tready <= 0;
         end else if (quiet_tail) begin
            rsp_tready <= 1;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 0;
         end else if ($urandom_range(0, 3) == 0) begin
            rx_gap = $urandom_range(1, 10) - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // long receiver hold-off
   initial begin
      wait (rx_hold);
      repeat (300) @(posedge clock);
      rx_hold = 0;
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("datagram_loss_span_tracker_top_test: FAIL");
         $finish;
      end
   end

   task automatic test_directed;
      header_type h;
      h = good_header(0, 1, 0);
      h.len = 15; send_header(h);
      h.len = 2047; send_header(h);
      h.len = 0; send_header(h);
      h.len = MIN_LEN; send_header(h);
      h.len = max_len_reg; h.magic = ~magic_reg; send_header(h);
      h = good_header(1, 0, 0); send_header(h);
      h = good_header(1, 1025, 0); send_header(h);
      h = good_header(1, 32'hFFFF_FFFF, 0); send_header(h);
      h = good_header(1, 4, 4); send_header(h);
      h = good_header(1, 4, 32'hFFFF_FFFF); send_header(h);
      h = good_header(256, 4, 1); send_header(h);
      h = good_header(32'hFFFF_FFFF, 4, 1); send_header(h);
      h = good_header(255, NCOUNT, NCOUNT - 1); send_header(h);
      h = good_header(255, NCOUNT, 0); h.user_time = 0; h.kernel_time = 0; send_header(h);
      h = good_header(255, NCOUNT, 0); h.kernel_time = '1; send_header(h);
      h = good_header(255, NCOUNT, 5); h.user_time = '1; send_header(h);
      h = good_header(2, 3, 0); send_header(h);
      h = good_header(2, 3, 0); send_header(h);
      h = good_header(2, 3, 2); h.kernel_time = 1; send_header(h);
      h = good_header(2, 3, 1); send_header(h);
      h = good_header(2, 2, 1); send_header(h);
   endtask

   task automatic random_phase(int n);
      header_type h;
      int f, c;
      for (int i = 0; i < n; i++) begin
         f = $urandom_range(0, 7);
         c = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NCOUNT) : $urandom_range(1, 8);
         h = good_header(f, c, $urandom_range(0, c - 1));
         case ($urandom_range(0, 9))
            0: h = HDR_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom});
            1: h.frame = $urandom;
            2: h.seq = $urandom;
            default: ;
         endcase
         send_header(h);
      end
   endtask

   task automatic test_csr_settings;
      write_csr(CSR_MAX_LEN, 32'd16);
      write_csr(CSR_MAGIC, 32'h0);
      random_phase(40);
      drain();
      write_csr(CSR_MAX_LEN, 32'd2047);
      write_csr(CSR_MAGIC, 32'hFFFF_FFFF);
      random_phase(40);
      drain();
      write_csr(CSR_MAGIC, $urandom);
      write_csr(CSR_MAX_LEN, $urandom_range(16, 2047));
      random_phase(40);
      drain();
      write_csr(CSR_MAGIC, MAGIC_RESET);
      write_csr(CSR_MAX_LEN, MAX_LEN_RESET);
   endtask

   task automatic test_backpressure;
      rx_hold = 1;
      random_phase(30);
      drain();
   endtask

   task automatic test_random;
      random_phase(300);
      drain();
      quiet_tail = 1;
      random_phase(60);
   endtask

   initial begin
      magic_reg = MAGIC_RESET;
      max_len_reg = MAX_LEN_RESET;
      for (int f = 0; f < NFRAMES; f++) begin
         rec_expected[f] = 0; rec_received[f] = 0;
         rec_user_first[f] = 0; rec_user_last[f] = 0;
         rec_kern_first[f] = 0; rec_kern_last[f] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      drain();
      test_csr_settings();
      test_backpressure();
      test_random();
      drain();
      if (errors == 0)
         $display("datagram_loss_span_tracker_top_test: PASS");
      else
         $display("datagram_loss_span_tracker_top_test: FAIL");
      $finish;
   end

endmodule
